>>> rtl/core/penum_pkg.sv
// ----------------------------------------------------------------------------
// penum_pkg
// Shared types and constants of the permutation enumerator: opcodes, status
// codes, controller states and the command and status bundles.
// ----------------------------------------------------------------------------
package penum_pkg;

  localparam int MAX_N_DEF = 8;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_NEXT   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_RSVD   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_ELEMENT   = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_EXHAUSTED = 2'd2,
    ST_DROPPED   = 2'd3
  } status_t;

  // write port source of the working list
  typedef enum logic [1:0] {
    WS_COPY,
    WS_SWAP_A,
    WS_SWAP_B
  } wsel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_STAT,
    S_COPY_RD,
    S_COPY_WR,
    S_EMIT_RD,
    S_EMIT_WAIT,
    S_ADV_LOAD,
    S_SW_RD,
    S_SW_WA,
    S_SW_WB,
    S_ADV_INC
  } state_t;

  typedef struct packed {
    logic    append;
    logic    clear;
    logic    set_started;
    logic    set_done;
    logic    idx_clr;
    logic    idx_inc;
    logic    rd_en;
    logic    rd_swap;
    logic    work_wr;
    wsel_t   wsel;
    logic    ctr_fill_all;
    logic    ctr_step;
    logic    ctr_wrap;
    logic    cur_load;
    logic    lvl_init;
    logic    lvl_dec;
    logic    out_load_elem;
    logic    out_load_stat;
    status_t stat_code;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic count_zero;
    logic started;
    logic done;
    logic idx_last;
    logic lvl_zero;
    logic step_ok;
    logic out_free;
  } sts_t;

endpackage

>>> rtl/core/penum_ctrl.sv
// ----------------------------------------------------------------------------
// penum_ctrl
// Sequencer of the permutation enumerator: decodes transactions, walks the
// copy, advance, swap and emit phases and drives the datapath commands.
// ----------------------------------------------------------------------------
module penum_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          opcode,
  input  penum_pkg::sts_t     sts,
  output penum_pkg::cmd_t     cmd
);

  penum_pkg::state_t  state, state_next;
  penum_pkg::status_t stat_code, stat_code_next;
  logic               second, second_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= penum_pkg::S_IDLE;
      stat_code <= penum_pkg::ST_ELEMENT;
      second    <= 1'b0;
    end else begin
      state     <= state_next;
      stat_code <= stat_code_next;
      second    <= second_next;
    end
  end

  always_comb begin
    state_next     = state;
    stat_code_next = stat_code;
    second_next    = second;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.wsel       = penum_pkg::WS_COPY;
    cmd.stat_code  = stat_code;
    unique case (state)
      penum_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (penum_pkg::opcode_t'(opcode))
            penum_pkg::OP_APPEND: begin
              if (sts.full) begin
                stat_code_next = penum_pkg::ST_DROPPED;
                state_next     = penum_pkg::S_STAT;
              end else begin
                cmd.append = 1'b1;
              end
            end
            penum_pkg::OP_CLEAR: begin
              cmd.clear = 1'b1;
            end
            penum_pkg::OP_NEXT: begin
              if (sts.done) begin
                stat_code_next = penum_pkg::ST_EXHAUSTED;
                state_next     = penum_pkg::S_STAT;
              end else if (sts.count_zero) begin
                cmd.set_started = 1'b1;
                cmd.set_done    = 1'b1;
                stat_code_next  = penum_pkg::ST_EMPTY;
                state_next      = penum_pkg::S_STAT;
              end else if (!sts.started) begin
                cmd.set_started = 1'b1;
                cmd.idx_clr     = 1'b1;
                state_next      = penum_pkg::S_COPY_RD;
              end else begin
                cmd.lvl_init = 1'b1;
                state_next   = penum_pkg::S_ADV_LOAD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      penum_pkg::S_STAT: begin
        if (sts.out_free) begin
          cmd.out_load_stat = 1'b1;
          state_next        = penum_pkg::S_IDLE;
        end
      end
      penum_pkg::S_COPY_RD: begin
        state_next = penum_pkg::S_COPY_WR;
      end
      penum_pkg::S_COPY_WR: begin
        cmd.work_wr = 1'b1;
        cmd.wsel    = penum_pkg::WS_COPY;
        if (sts.idx_last) begin
          cmd.idx_clr      = 1'b1;
          cmd.ctr_fill_all = 1'b1;
          state_next       = penum_pkg::S_EMIT_RD;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = penum_pkg::S_COPY_RD;
        end
      end
      penum_pkg::S_EMIT_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = penum_pkg::S_EMIT_WAIT;
      end
      penum_pkg::S_EMIT_WAIT: begin
        if (sts.out_free) begin
          cmd.out_load_elem = 1'b1;
          if (sts.idx_last) begin
            state_next = penum_pkg::S_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = penum_pkg::S_EMIT_RD;
          end
        end
      end
      penum_pkg::S_ADV_LOAD: begin
        cmd.cur_load = 1'b1;
        state_next   = penum_pkg::S_SW_RD;
      end
      penum_pkg::S_SW_RD: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_swap = 1'b1;
        state_next  = penum_pkg::S_SW_WA;
      end
      penum_pkg::S_SW_WA: begin
        cmd.work_wr = 1'b1;
        cmd.wsel    = penum_pkg::WS_SWAP_A;
        state_next  = penum_pkg::S_SW_WB;
      end
      penum_pkg::S_SW_WB: begin
        cmd.work_wr = 1'b1;
        cmd.wsel    = penum_pkg::WS_SWAP_B;
        if (second) begin
          second_next = 1'b0;
          cmd.idx_clr = 1'b1;
          state_next  = penum_pkg::S_EMIT_RD;
        end else begin
          state_next = penum_pkg::S_ADV_INC;
        end
      end
      penum_pkg::S_ADV_INC: begin
        if (sts.step_ok) begin
          cmd.ctr_step = 1'b1;
          second_next  = 1'b1;
          state_next   = penum_pkg::S_SW_RD;
        end else begin
          cmd.ctr_wrap = 1'b1;
          if (sts.lvl_zero) begin
            cmd.set_done   = 1'b1;
            stat_code_next = penum_pkg::ST_EXHAUSTED;
            state_next     = penum_pkg::S_STAT;
          end else begin
            cmd.lvl_dec = 1'b1;
            state_next  = penum_pkg::S_ADV_LOAD;
          end
        end
      end
      default: begin
        state_next = penum_pkg::S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/penum_dp.sv
// ----------------------------------------------------------------------------
// penum_dp
// Datapath of the permutation enumerator: original and working lists, the
// per-level loop counter stack, enumeration flags and the output register.
// ----------------------------------------------------------------------------
module penum_dp #(
  parameter int MAX_N = penum_pkg::MAX_N_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic signed [31:0] element_value,
  input  penum_pkg::cmd_t    cmd,
  output penum_pkg::sts_t    sts,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_value,
  output logic [1:0]         status,
  output logic               last_of_permutation
);

  localparam int IW = (MAX_N > 1) ? $clog2(MAX_N) : 1;
  localparam int CW = $clog2(MAX_N + 1);

  logic [31:0]   orig_mem [MAX_N];
  logic [31:0]   work_mem [MAX_N];
  logic [IW-1:0] counters [MAX_N];

  logic [CW-1:0] count;
  logic          started;
  logic          done;
  logic [IW-1:0] idx;
  logic [IW-1:0] lvl;
  logic [CW-1:0] cur;
  logic [31:0]   orig_q;
  logic [31:0]   rda;
  logic [31:0]   rdb;

  logic [CW-1:0] cur_inc;
  logic [IW-1:0] rda_addr;
  logic [IW-1:0] wr_addr;
  logic [31:0]   wr_data;
  logic          out_last_q;
  logic          out_load;

  assign cur_inc  = cur + CW'(1);
  assign rda_addr = cmd.rd_swap ? cur[IW-1:0] : idx;
  assign out_load = cmd.out_load_elem | cmd.out_load_stat;

  always_comb begin
    unique case (cmd.wsel)
      penum_pkg::WS_SWAP_A: begin
        wr_addr = cur[IW-1:0];
        wr_data = rdb;
      end
      penum_pkg::WS_SWAP_B: begin
        wr_addr = lvl;
        wr_data = rda;
      end
      default: begin
        wr_addr = idx;
        wr_data = orig_q;
      end
    endcase
  end

  // list storage
  always_ff @(posedge clk) begin
    if (cmd.append) begin
      orig_mem[count[IW-1:0]] <= element_value;
    end
    orig_q <= orig_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.work_wr) begin
      work_mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rda <= work_mem[rda_addr];
      rdb <= work_mem[lvl];
    end
  end

  // enumeration control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      started <= 1'b0;
      done    <= 1'b0;
      for (int j = 0; j < MAX_N; j++) begin
        counters[j] <= '0;
      end
    end else begin
      if (cmd.clear) begin
        count <= '0;
      end else if (cmd.append) begin
        count <= count + CW'(1);
      end
      if (cmd.clear || cmd.append) begin
        started <= 1'b0;
        done    <= 1'b0;
      end else begin
        if (cmd.set_started) begin
          started <= 1'b1;
        end
        if (cmd.set_done) begin
          done <= 1'b1;
        end
      end
      for (int j = 0; j < MAX_N; j++) begin
        if (cmd.clear || cmd.append) begin
          counters[j] <= '0;
        end else if (cmd.ctr_fill_all) begin
          counters[j] <= IW'(j);
        end else if (cmd.ctr_step) begin
          if (IW'(j) == lvl) begin
            counters[j] <= cur_inc[IW-1:0];
          end else if (IW'(j) > lvl) begin
            counters[j] <= IW'(j);
          end
        end else if (cmd.ctr_wrap && IW'(j) == lvl) begin
          counters[j] <= lvl;
        end
      end
    end
  end

  // position, level and loop index registers
  always_ff @(posedge clk) begin
    if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + IW'(1);
    end
    if (cmd.lvl_init) begin
      lvl <= IW'(count - CW'(1));
    end else if (cmd.lvl_dec) begin
      lvl <= lvl - IW'(1);
    end
    if (cmd.cur_load) begin
      cur <= CW'(counters[lvl]);
    end else if (cmd.ctr_step) begin
      cur <= cur_inc;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load_elem) begin
      out_value  <= rda;
      status     <= penum_pkg::ST_ELEMENT;
      out_last_q <= sts.idx_last;
    end else if (cmd.out_load_stat) begin
      out_value  <= '0;
      status     <= cmd.stat_code;
      out_last_q <= 1'b1;
    end
  end

  assign last_of_permutation = out_last_q;

  assign sts.full       = (count == CW'(MAX_N));
  assign sts.count_zero = (count == '0);
  assign sts.started    = started;
  assign sts.done       = done;
  assign sts.idx_last   = (CW'(idx) == count - CW'(1));
  assign sts.lvl_zero   = (lvl == '0);
  assign sts.step_ok    = (cur_inc < count);
  assign sts.out_free   = !out_valid || out_ready;

`ifndef SYNTHESIS
  a_done_implies_started: assert property (@(posedge clk) disable iff (rst)
    done |-> started)
    else $error("enumeration done without being started");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_N))
    else $error("element count beyond list capacity");

  a_status_is_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != penum_pkg::ST_ELEMENT) |-> last_of_permutation)
    else $error("status transaction not marked last");

  a_no_load_over_pending: assert property (@(posedge clk) disable iff (rst)
    out_load |-> !out_valid || out_ready)
    else $error("output register overwritten before transfer");
`endif

endmodule

>>> rtl/core/permutation_enumerator.sv
// ----------------------------------------------------------------------------
// permutation_enumerator
// Loads a list of signed values and emits its permutations one at a time in
// the order of the recursive swap, recurse, swap-back enumeration.
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid/in_ready): opcode append, next, clear; one
//   transaction at a time, in_ready is high only while the sequencer is idle
//   output channel (out_valid/out_ready): one transaction per element of the
//   permutation, last_of_permutation on the final one; status transactions
//   (empty, exhausted, load dropped) are single transactions with value 0
//   append and clear return nothing; a status reply is registered in the
//   sequencer's status state, then loaded into the output register
//   next, first permutation: the loaded list is copied element by element
//   into the working list, then each element is emitted
//   next, later permutations: a swap-back per level unwound through the
//   counter stack and a swap-back and swap for the level that steps, each
//   working list swap made through its single write port, then each element is emitted
//   stall: the output register holds a transaction until out_ready; the
//   sequencer waits on it, nothing is lost
//   reset: list empty, enumeration restarted, output channel idle
// ----------------------------------------------------------------------------
module permutation_enumerator #(
  parameter int MAX_N = penum_pkg::MAX_N_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         opcode,
  input  logic signed [31:0] element_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_value,
  output logic [1:0]         status,
  output logic               last_of_permutation
);

  // command bundle from the sequencer, status bundle back from the datapath
  penum_pkg::cmd_t cmd;
  penum_pkg::sts_t sts;

  penum_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .opcode   (opcode),
    .sts      (sts),
    .cmd      (cmd)
  );

  // lists, loop counter stack and output register
  penum_dp #(
    .MAX_N (MAX_N)
  ) u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .element_value       (element_value),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_value           (out_value),
    .status              (status),
    .last_of_permutation (last_of_permutation)
  );

endmodule
